// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks on the rising clock edge, with and without reset masking
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check masked while reset is high
`define SPI_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that also holds across reset
`define SPI_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/spi_pkg.sv =====
// ----------------------------------------------------------------------------
// speed pi package
// shared widths, register indexes, reset values and control types
// ----------------------------------------------------------------------------
package spi_pkg;

   localparam int CNT_W      = 16;
   localparam int SUM_W      = 17;
   localparam int TILT_W     = 16;
   localparam int MOVE_W     = 23;
   localparam int FS_W       = 25;
   localparam int DI_W       = 24;
   localparam int GAIN_W     = 16;
   localparam int LIMIT_W    = 15;
   localparam int WEIGHT_W   = 9;
   localparam int OPA_W      = 25;
   localparam int OPB_W      = 17;
   localparam int PROD_W     = OPA_W + OPB_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_GAIN        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGRAL_GAIN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGRAL_LIMIT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TILT_LIMIT        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NEW_SAMPLE_WEIGHT = 3'd4;

   localparam logic [GAIN_W-1:0]   SPEED_GAIN_RST        = 16'd21760;
   localparam logic [GAIN_W-1:0]   INTEGRAL_GAIN_RST     = 16'd64;
   localparam logic [LIMIT_W-1:0]  INTEGRAL_LIMIT_RST    = 15'd10000;
   localparam logic [LIMIT_W-1:0]  TILT_LIMIT_RST        = 15'd7680;
   localparam logic [WEIGHT_W-1:0] NEW_SAMPLE_WEIGHT_RST = 9'd51;

   localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 9'd256;
   localparam logic [DI_W-1:0]     DI_MAX      = 24'h7FFFFF;
   localparam logic [FS_W-1:0]     FS_MAX      = 25'h0FFFFFF;
   localparam logic [FS_W-1:0]     FS_MIN      = 25'h1000000;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_MUL_A = 10'b0000000010,
      S_MUL_B = 10'b0000000100,
      S_ACC_B = 10'b0000001000,
      S_FILT  = 10'b0000010000,
      S_INTEG = 10'b0000100000,
      S_MUL_C = 10'b0001000000,
      S_MUL_D = 10'b0010000000,
      S_ACC_D = 10'b0100000000,
      S_DRIVE = 10'b1000000000
   } state_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_ADD_SH
   } acc_op_type;

   typedef struct packed {
      logic       mul_en;
      acc_op_type acc_op;
   } mac_ctrl_type;

endpackage

// ===== hw/rtl/speed_pi_with_lowpass_and_clamp.sv =====
// ----------------------------------------------------------------------------
// speed pi controller with low-pass and integral clamp
// One control tick per transfer: the wheel counts are summed and low-pass
// filtered, the filtered speed is integrated against the movement setpoint
// under a symmetric clamp, and the drive is formed as a PI sum, rounded and
// saturated to 25 bits; an excessive tilt raises motor_off and clears the
// integral. All four products go through one registered 25x17 multiplier
// and accumulator under a ten-state sequencer, so the block takes no new
// transfer until the sequence is back in idle; a stalled result holds the
// final step until it is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module speed_pi_with_lowpass_and_clamp #(
   parameter int FRACTION_BITS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [spi_pkg::CNT_W-1:0]       req_left_count,
   input  logic signed [spi_pkg::CNT_W-1:0]       req_right_count,
   input  logic signed [spi_pkg::TILT_W-1:0]      req_tilt_angle,
   input  logic signed [spi_pkg::MOVE_W-1:0]      req_movement,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [spi_pkg::FS_W-1:0]        rsp_velocity_drive,
   output logic                                   rsp_motor_off,
   input  logic                                   csr_we,
   input  logic [spi_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [spi_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   localparam int ACC_W  = (FRACTION_BITS + 27 > 42) ? FRACTION_BITS + 27 : 42;
   localparam int LIMW   = (spi_pkg::LIMIT_W + FRACTION_BITS > spi_pkg::DI_W) ?
                           spi_pkg::LIMIT_W + FRACTION_BITS : spi_pkg::DI_W;
   localparam int INTW   = 27;
   localparam logic signed [ACC_W-1:0] FILT_HALF = ACC_W'(128);
   localparam logic signed [ACC_W-1:0] DRV_HALF  = ACC_W'(1) <<< (FRACTION_BITS + 7);

   // configuration
   logic [spi_pkg::GAIN_W-1:0]   speed_gain_ff, speed_gain_in;
   logic [spi_pkg::GAIN_W-1:0]   integral_gain_ff, integral_gain_in;
   logic [spi_pkg::LIMIT_W-1:0]  integral_limit_ff, integral_limit_in;
   logic [spi_pkg::LIMIT_W-1:0]  tilt_limit_ff, tilt_limit_in;
   logic [spi_pkg::WEIGHT_W-1:0] weight_ff, weight_in;

   // control and state
   spi_pkg::state_type                  state_ff, state_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [spi_pkg::FS_W-1:0]     fs_ff, fs_in;
   logic signed [spi_pkg::DI_W-1:0]     di_ff, di_in;

   // payload
   logic signed [spi_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic signed [spi_pkg::TILT_W-1:0]   tilt_ff, tilt_in;
   logic signed [spi_pkg::MOVE_W-1:0]   move_ff, move_in;
   logic signed [spi_pkg::FS_W-1:0]     drive_ff, drive_in;
   logic                                off_ff, off_in;

   // datapath
   spi_pkg::mac_ctrl_type               mac_ctrl;
   logic signed [spi_pkg::OPA_W-1:0]    op_a;
   logic signed [spi_pkg::OPB_W-1:0]    op_b;
   logic signed [ACC_W-1:0]             acc;
   logic [spi_pkg::WEIGHT_W-1:0]        w_eff;
   logic [spi_pkg::WEIGHT_W-1:0]        w_inv;
   logic signed [ACC_W-1:0]             filt_q;
   logic                                filt_fits;
   logic signed [spi_pkg::FS_W-1:0]     filt_sat;
   logic signed [ACC_W-1:0]             drv_q;
   logic                                drv_fits;
   logic signed [spi_pkg::FS_W-1:0]     drv_sat;
   logic [LIMW-1:0]                     lim_wide;
   logic [spi_pkg::DI_W-1:0]            lim_cap;
   logic signed [INTW-1:0]              lim_pos;
   logic signed [INTW-1:0]              lim_neg;
   logic signed [INTW-1:0]              integ_sum;
   logic signed [INTW-1:0]              integ_clamp;
   logic [spi_pkg::TILT_W:0]            tilt_abs;
   logic                                tilt_off;
   logic                                req_fire;
   logic                                drive_go;

   assign req_fire = req_valid && req_ready;
   assign drive_go = !rsp_valid_ff || rsp_ready;

   // weights
   assign w_eff = (weight_ff > spi_pkg::WEIGHT_FULL) ? spi_pkg::WEIGHT_FULL : weight_ff;
   assign w_inv = spi_pkg::WEIGHT_FULL - w_eff;

   // operand selection and mac control
   always_comb begin
      op_a = fs_ff;
      op_b = spi_pkg::OPB_W'(signed'(speed_gain_ff));
      mac_ctrl.mul_en = 1'b0;
      mac_ctrl.acc_op = spi_pkg::ACC_HOLD;
      case (state_ff)
         spi_pkg::S_MUL_A: begin
            op_b = signed'({8'd0, w_inv});
            mac_ctrl.mul_en = 1'b1;
         end
         spi_pkg::S_MUL_B: begin
            op_a = spi_pkg::OPA_W'(sum_ff);
            op_b = signed'({8'd0, w_eff});
            mac_ctrl.mul_en = 1'b1;
            mac_ctrl.acc_op = spi_pkg::ACC_LOAD;
         end
         spi_pkg::S_ACC_B: begin
            mac_ctrl.acc_op = spi_pkg::ACC_ADD_SH;
         end
         spi_pkg::S_MUL_C: begin
            mac_ctrl.mul_en = 1'b1;
         end
         spi_pkg::S_MUL_D: begin
            op_a = spi_pkg::OPA_W'(di_ff);
            op_b = spi_pkg::OPB_W'(signed'(integral_gain_ff));
            mac_ctrl.mul_en = 1'b1;
            mac_ctrl.acc_op = spi_pkg::ACC_LOAD;
         end
         spi_pkg::S_ACC_D: begin
            mac_ctrl.acc_op = spi_pkg::ACC_ADD;
         end
         default: begin
            mac_ctrl.acc_op = spi_pkg::ACC_HOLD;
         end
      endcase
   end

   spi_mac #(
      .FRACTION_BITS (FRACTION_BITS),
      .ACC_W         (ACC_W)
   ) u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .op_a  (op_a),
      .op_b  (op_b),
      .acc   (acc)
   );

   // rounding and saturation
   assign filt_q    = (acc + FILT_HALF) >>> 8;
   assign filt_fits = (&filt_q[ACC_W-1:spi_pkg::FS_W-1]) || !(|filt_q[ACC_W-1:spi_pkg::FS_W-1]);
   assign filt_sat  = filt_fits ? filt_q[spi_pkg::FS_W-1:0] :
                      (filt_q[ACC_W-1] ? spi_pkg::FS_MIN : spi_pkg::FS_MAX);

   assign drv_q     = (acc + DRV_HALF) >>> (FRACTION_BITS + 8);
   assign drv_fits  = (&drv_q[ACC_W-1:spi_pkg::FS_W-1]) || !(|drv_q[ACC_W-1:spi_pkg::FS_W-1]);
   assign drv_sat   = drv_fits ? drv_q[spi_pkg::FS_W-1:0] :
                      (drv_q[ACC_W-1] ? spi_pkg::FS_MIN : spi_pkg::FS_MAX);

   // integral clamp
   assign lim_wide  = LIMW'(integral_limit_ff) << FRACTION_BITS;
   assign lim_cap   = (lim_wide > LIMW'(spi_pkg::DI_MAX)) ? spi_pkg::DI_MAX :
                      lim_wide[spi_pkg::DI_W-1:0];
   assign lim_pos   = signed'({3'd0, lim_cap});
   assign lim_neg   = -lim_pos;
   assign integ_sum = INTW'(di_ff) + INTW'(fs_ff) - INTW'(move_ff);
   assign integ_clamp = (integ_sum > lim_pos) ? lim_pos :
                        ((integ_sum < lim_neg) ? lim_neg : integ_sum);

   // tilt check
   assign tilt_abs = tilt_ff[spi_pkg::TILT_W-1] ? 17'(-(17'(tilt_ff))) : 17'(tilt_ff);
   assign tilt_off = tilt_abs > {2'd0, tilt_limit_ff};

   // configuration writes
   always_comb begin
      speed_gain_in     = speed_gain_ff;
      integral_gain_in  = integral_gain_ff;
      integral_limit_in = integral_limit_ff;
      tilt_limit_in     = tilt_limit_ff;
      weight_in         = weight_ff;
      if (csr_we) begin
         case (csr_index)
            spi_pkg::CSR_SPEED_GAIN:        speed_gain_in     = csr_wdata;
            spi_pkg::CSR_INTEGRAL_GAIN:     integral_gain_in  = csr_wdata;
            spi_pkg::CSR_INTEGRAL_LIMIT:    integral_limit_in = csr_wdata[spi_pkg::LIMIT_W-1:0];
            spi_pkg::CSR_TILT_LIMIT:        tilt_limit_in     = csr_wdata[spi_pkg::LIMIT_W-1:0];
            spi_pkg::CSR_NEW_SAMPLE_WEIGHT: weight_in         = csr_wdata[spi_pkg::WEIGHT_W-1:0];
            default:                        weight_in         = weight_ff;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      fs_in        = fs_ff;
      di_in        = di_ff;
      sum_in       = sum_ff;
      tilt_in      = tilt_ff;
      move_in      = move_ff;
      drive_in     = drive_ff;
      off_in       = off_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         spi_pkg::S_IDLE: begin
            if (req_fire) begin
               sum_in   = spi_pkg::SUM_W'(req_left_count) + spi_pkg::SUM_W'(req_right_count);
               tilt_in  = req_tilt_angle;
               move_in  = req_movement;
               state_in = spi_pkg::S_MUL_A;
            end
         end
         spi_pkg::S_MUL_A: state_in = spi_pkg::S_MUL_B;
         spi_pkg::S_MUL_B: state_in = spi_pkg::S_ACC_B;
         spi_pkg::S_ACC_B: state_in = spi_pkg::S_FILT;
         spi_pkg::S_FILT: begin
            fs_in    = filt_sat;
            state_in = spi_pkg::S_INTEG;
         end
         spi_pkg::S_INTEG: begin
            di_in    = integ_clamp[spi_pkg::DI_W-1:0];
            state_in = spi_pkg::S_MUL_C;
         end
         spi_pkg::S_MUL_C: state_in = spi_pkg::S_MUL_D;
         spi_pkg::S_MUL_D: state_in = spi_pkg::S_ACC_D;
         spi_pkg::S_ACC_D: state_in = spi_pkg::S_DRIVE;
         spi_pkg::S_DRIVE: begin
            if (drive_go) begin
               drive_in     = drv_sat;
               off_in       = tilt_off;
               rsp_valid_in = 1'b1;
               if (tilt_off) begin
                  di_in = '0;
               end
               state_in = spi_pkg::S_IDLE;
            end
         end
         default: state_in = spi_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_gain_ff     <= spi_pkg::SPEED_GAIN_RST;
         integral_gain_ff  <= spi_pkg::INTEGRAL_GAIN_RST;
         integral_limit_ff <= spi_pkg::INTEGRAL_LIMIT_RST;
         tilt_limit_ff     <= spi_pkg::TILT_LIMIT_RST;
         weight_ff         <= spi_pkg::NEW_SAMPLE_WEIGHT_RST;
         state_ff          <= spi_pkg::S_IDLE;
         rsp_valid_ff      <= 1'b0;
         fs_ff             <= '0;
         di_ff             <= '0;
      end else begin
         speed_gain_ff     <= speed_gain_in;
         integral_gain_ff  <= integral_gain_in;
         integral_limit_ff <= integral_limit_in;
         tilt_limit_ff     <= tilt_limit_in;
         weight_ff         <= weight_in;
         state_ff          <= state_in;
         rsp_valid_ff      <= rsp_valid_in;
         fs_ff             <= fs_in;
         di_ff             <= di_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      tilt_ff  <= tilt_in;
      move_ff  <= move_in;
      drive_ff <= drive_in;
      off_ff   <= off_in;
   end

   assign req_ready          = (state_ff == spi_pkg::S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_velocity_drive = drive_ff;
   assign rsp_motor_off      = off_ff;

   // checks
   `SPI_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == spi_pkg::S_IDLE) && !rsp_valid_ff, "reset did not return to idle")
   `SPI_ASSERT(a_accept_starts, req_fire |=> state_ff == spi_pkg::S_MUL_A, "transfer did not start the sequence")
   `SPI_ASSERT(a_drive_stall, (state_ff == spi_pkg::S_DRIVE) && !drive_go |=> state_ff == spi_pkg::S_DRIVE, "final step left while result pending")
   `SPI_ASSERT(a_off_clears, (state_ff == spi_pkg::S_DRIVE) && drive_go && tilt_off |=> di_ff == '0, "integral not cleared on motor off")

endmodule

// ===== hw/rtl/spi_mac.sv =====
// ----------------------------------------------------------------------------
// speed pi multiply-accumulate unit
// one registered signed multiplier feeding an accumulator with optional
// fraction alignment shift
// ----------------------------------------------------------------------------
module spi_mac #(
   parameter int FRACTION_BITS = 8,
   parameter int ACC_W         = 42
) (
   input  logic                              clock,
   input  spi_pkg::mac_ctrl_type             ctrl,
   input  logic signed [spi_pkg::OPA_W-1:0]  op_a,
   input  logic signed [spi_pkg::OPB_W-1:0]  op_b,
   output logic signed [ACC_W-1:0]           acc
);

   logic signed [spi_pkg::PROD_W-1:0] a_ext;
   logic signed [spi_pkg::PROD_W-1:0] b_ext;
   logic signed [spi_pkg::PROD_W-1:0] prod_ff;
   logic signed [spi_pkg::PROD_W-1:0] prod_in;
   logic signed [ACC_W-1:0]           prod_acc;
   logic signed [ACC_W-1:0]           acc_ff;
   logic signed [ACC_W-1:0]           acc_in;

   assign a_ext    = spi_pkg::PROD_W'(op_a);
   assign b_ext    = spi_pkg::PROD_W'(op_b);
   assign prod_acc = ACC_W'(prod_ff);

   always_comb begin
      prod_in = ctrl.mul_en ? a_ext * b_ext : prod_ff;
      case (ctrl.acc_op)
         spi_pkg::ACC_LOAD:   acc_in = prod_acc;
         spi_pkg::ACC_ADD:    acc_in = acc_ff + prod_acc;
         spi_pkg::ACC_ADD_SH: acc_in = acc_ff + (prod_acc <<< FRACTION_BITS);
         default:             acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule
